// ----- rtl/pds_pkg.sv -----
// Shared types and constants for the paired deck shuffle block.
`default_nettype none
package pds_pkg;

	// Field widths
	localparam int FACE_W = 5;
	localparam int POS_W  = 6;
	localparam int PAIR_W = 6;
	localparam int SEED_W = 64;
	// Modulus of one draw: up to 64, so one bit over a position
	localparam int MOD_W  = 7;

	// xorshift64* constants
	localparam logic [SEED_W-1:0] XS_MULT = 64'h2545_F491_4F6C_DD1D;
	localparam int XS_SH_A = 12;
	localparam int XS_SH_B = 25;
	localparam int XS_SH_C = 27;

	// Request from the sequencer to the draw unit
	typedef struct packed {
		logic              load;     // reload generator from seed
		logic [SEED_W-1:0] seed;
		logic              start;    // run one draw and reduce it
		logic [MOD_W-1:0]  modulus;  // draw is taken modulo this
	} draw_req_t;

	// Answer from the draw unit
	typedef struct packed {
		logic             done;      // one-cycle pulse, pick is valid
		logic [POS_W-1:0] pick;      // swap partner position
	} draw_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/pds_draw.sv -----
// Generator step, 64-bit scramble multiply and serial remainder for one shuffle draw.
`default_nettype none
module pds_draw (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pds_pkg::draw_req_t req,
	output pds_pkg::draw_rsp_t   rsp
);
	import pds_pkg::*;

	localparam int HALF_W  = SEED_W / 2;
	localparam int MOD_STEPS = SEED_W / 2;          // two bits per cycle
	localparam int CNT_W   = $clog2(MOD_STEPS);

	typedef enum logic [6:0] {
		D_IDLE = 7'b000_0001,
		D_XS   = 7'b000_0010,
		D_M0   = 7'b000_0100,
		D_M1   = 7'b000_1000,
		D_M2   = 7'b001_0000,
		D_M3   = 7'b010_0000,
		D_MOD  = 7'b100_0000
	} dstate_t;

	dstate_t              state_q;
	logic [SEED_W-1:0]    rng_q;
	logic [SEED_W-1:0]    acc_q;
	logic [SEED_W-1:0]    prod_q;
	logic [MOD_W-1:0]     mod_q;
	logic [MOD_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;

	logic [SEED_W-1:0]    xs_a, xs_b, xs_c;
	logic [HALF_W-1:0]    mul_a, mul_b;
	logic [MOD_W-1:0]     rem_1, rem_2;

	// One restoring remainder step: shift a bit in, subtract if it fits
	function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] r,
			input logic b, input logic [MOD_W-1:0] m);
		logic [MOD_W:0] t;
		t = {r, b};
		if (t >= {1'b0, m})
			t = t - {1'b0, m};
		return t[MOD_W-1:0];
	endfunction

	// xorshift64 step
	always_comb begin
		xs_a = rng_q ^ (rng_q >> XS_SH_A);
		xs_b = xs_a ^ (xs_a << XS_SH_B);
		xs_c = xs_b ^ (xs_b >> XS_SH_C);
	end

	// Shared 32x32 multiplier: low*low, high*low, low*high partial products
	always_comb begin
		unique case (state_q)
			D_M1: begin
				mul_a = rng_q[SEED_W-1:HALF_W];
				mul_b = XS_MULT[HALF_W-1:0];
			end
			D_M2: begin
				mul_a = rng_q[HALF_W-1:0];
				mul_b = XS_MULT[SEED_W-1:HALF_W];
			end
			default: begin
				mul_a = rng_q[HALF_W-1:0];
				mul_b = XS_MULT[HALF_W-1:0];
			end
		endcase
	end

	// Two remainder bits per cycle, MSB first
	always_comb begin
		rem_1 = mod_step(rem_q, acc_q[SEED_W-1], mod_q);
		rem_2 = mod_step(rem_1, acc_q[SEED_W-2], mod_q);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			rng_q   <= SEED_W'(1);
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.load)
						rng_q <= (req.seed == '0) ? SEED_W'(1) : req.seed;
					if (req.start)
						state_q <= D_XS;
				end
				D_XS: begin
					rng_q   <= xs_c;
					state_q <= D_M0;
				end
				D_M0: state_q <= D_M1;
				D_M1: state_q <= D_M2;
				D_M2: state_q <= D_M3;
				D_M3: begin
					cnt_q   <= '0;
					state_q <= D_MOD;
				end
				D_MOD: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Datapath: products, low 64 bits of the scramble, remainder
	always_ff @(posedge clk) begin
		prod_q <= SEED_W'(mul_a) * SEED_W'(mul_b);
		if (state_q == D_IDLE && req.start)
			mod_q <= req.modulus;
		unique case (state_q)
			D_M1: acc_q <= prod_q;
			D_M2: acc_q[SEED_W-1:HALF_W] <= acc_q[SEED_W-1:HALF_W] + prod_q[HALF_W-1:0];
			D_M3: begin
				acc_q[SEED_W-1:HALF_W] <= acc_q[SEED_W-1:HALF_W] + prod_q[HALF_W-1:0];
				rem_q <= '0;
			end
			D_MOD: begin
				rem_q <= rem_2;
				acc_q <= acc_q << 2;
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.pick = rem_q[POS_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/paired_deck_shuffle_core.sv -----
// Paired deck shuffle: top level with card store, shuffle sequencer and output register.
// Each accepted word is a deal request: the pair count is saturated to 1..MAX_PAIR_COUNT,
// the store is filled with two cards per face, shuffled Fisher-Yates from the top position
// down using xorshift64* draws, and then one word per card goes out in position order with
// last_card set on the final one. One deal is handled at a time; in_ready is high only
// between deals, and a new deal may be taken while the final card still waits at the output.
// For P pairs a deal runs a fill of 2P cards, then 2P-1 shuffle steps, then one output word
// per card. Each step waits on the draw unit: a 3-pass 32x32 multiply and a 2-bit-per-cycle
// remainder over the 64-bit draw, followed by two reads and two writes on the card store.
`default_nettype none
module paired_deck_shuffle_core #(
	parameter int MAX_PAIR_COUNT = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [pds_pkg::PAIR_W-1:0] pair_request,
	input  wire logic [pds_pkg::SEED_W-1:0] seed_value,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [pds_pkg::POS_W-1:0]      position,
	output logic [pds_pkg::FACE_W-1:0]     face_id,
	output logic                           last_card
);
	import pds_pkg::*;

	localparam int DEPTH = 2 * MAX_PAIR_COUNT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_FILL    = 8'b0000_0010,
		S_DRAW    = 8'b0000_0100,
		S_RD_I    = 8'b0000_1000,
		S_RD_J    = 8'b0001_0000,
		S_WR_I    = 8'b0010_0000,
		S_WR_J    = 8'b0100_0000,
		S_EMIT_RD = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic                emit_ld_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       k_q;
	logic [AW-1:0]       i_q;
	logic [AW-1:0]       j_q;
	logic [FACE_W-1:0]   t_q;

	// Card store
	logic [FACE_W-1:0]   card_mem [DEPTH];
	logic [FACE_W-1:0]   rdata_q;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [FACE_W-1:0]   wdata;
	logic [AW-1:0]       raddr;

	// Output register
	logic                out_valid_q;
	logic [POS_W-1:0]    position_q;
	logic [FACE_W-1:0]   face_q;
	logic                last_q;

	draw_req_t           dreq;
	draw_rsp_t           drsp;

	logic                in_acc;
	logic [PAIR_W-1:0]   pairs_sat;
	logic                fill_last;
	logic                emit_go;
	logic                emit_last;

	pds_draw u_draw (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign in_ready = (state_q == S_IDLE) && !emit_ld_q;
	assign in_acc   = in_valid && in_ready;

	// Pair count saturation
	always_comb begin
		priority if (pair_request == '0)
			pairs_sat = PAIR_W'(1);
		else if ({1'b0, pair_request} > (PAIR_W + 1)'(MAX_PAIR_COUNT))
			pairs_sat = PAIR_W'(MAX_PAIR_COUNT);
		else
			pairs_sat = pair_request;
	end

	assign fill_last = ({1'b0, k_q} == (AW + 1)'(count_q - CW'(1)));
	assign emit_go   = !out_valid_q || out_ready;
	assign emit_last = fill_last;

	// Draw requests: first step at the end of fill, next one after each swap but the last
	always_comb begin
		dreq.load    = in_acc;
		dreq.seed    = seed_value;
		dreq.start   = (state_q == S_FILL && fill_last) ||
		               (state_q == S_WR_J && i_q != AW'(1));
		dreq.modulus = (state_q == S_FILL) ? MOD_W'(count_q) : MOD_W'(i_q);
	end

	// Store access per state
	always_comb begin
		we    = 1'b0;
		waddr = k_q;
		wdata = FACE_W'(k_q >> 1);
		raddr = k_q;
		unique case (state_q)
			S_FILL: we = 1'b1;
			S_RD_I: raddr = i_q;
			S_RD_J: raddr = j_q;
			S_WR_I: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata_q;
			end
			S_WR_J: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = t_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			card_mem[waddr] <= wdata;
		rdata_q <= card_mem[raddr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			emit_ld_q <= 1'b0;
			count_q   <= '0;
			k_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			emit_ld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						count_q <= CW'({pairs_sat, 1'b0});
						k_q     <= '0;
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (fill_last) begin
						i_q     <= AW'(count_q - CW'(1));
						state_q <= S_DRAW;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				S_DRAW: begin
					if (drsp.done) begin
						j_q     <= AW'(drsp.pick);
						state_q <= S_RD_I;
					end
				end
				S_RD_I: state_q <= S_RD_J;
				S_RD_J: state_q <= S_WR_I;
				S_WR_I: state_q <= S_WR_J;
				S_WR_J: begin
					if (i_q == AW'(1)) begin
						k_q     <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						i_q     <= i_q - AW'(1);
						state_q <= S_DRAW;
					end
				end
				S_EMIT_RD: begin
					// read card k into rdata_q; emit_ld_q then loads it into the output register
					if (emit_go && !emit_ld_q) begin
						emit_ld_q <= 1'b1;
						state_q   <= emit_last ? S_IDLE : S_EMIT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (emit_ld_q && state_q == S_EMIT_RD)
				k_q <= k_q + AW'(1);
		end
	end

	// Swap temp holds the card read from position i
	always_ff @(posedge clk) begin
		if (state_q == S_RD_J)
			t_q <= rdata_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (emit_ld_q)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ld_q) begin
			position_q <= POS_W'(k_q);
			face_q     <= rdata_q;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign face_id   = face_q;
	assign last_card = last_q;

endmodule
`default_nettype wire
